[hw/rtl/vrs_pkg.sv]
// Shared types, constants and ramp tables for the valve ramp sequencer.
package vrs_pkg;

    localparam int NUM_VALVES_DEF = 3;
    localparam int MAX_RESULTS    = 5;
    localparam int RES_CW         = 3;
    localparam int MV_W           = 14;
    localparam int STAMP_W        = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_W-1:0] RAMP_STEP_RST     = 16'd20;
    localparam logic [CFG_W-1:0] INFLATE_HOLD_RST  = 16'd180;
    localparam logic [CFG_W-1:0] DEFLATE_HOLD_RST  = 16'd140;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_SET   = 1'b1;
    localparam logic KIND_VOLT = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef enum logic [1:0] {
        PH_UP        = 2'd0,
        PH_DOWN      = 2'd1,
        PH_UP_DONE   = 2'd2,
        PH_DOWN_DONE = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAMP_STEP    = 2'd0,
        REG_INFLATE_HOLD = 2'd1,
        REG_DEFLATE_HOLD = 2'd2,
        REG_SEQ_ENABLE   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_SEQ,
        ST_FIN,
        ST_SET,
        ST_ACK,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic       command;
        logic [2:0] valve_index;
        logic [1:0] new_state;
    } in_t;

    typedef struct packed {
        logic            kind;
        logic [2:0]      valve;
        logic [MV_W-1:0] voltage_mv;
        logic            ok;
        logic            last;
    } out_t;

    // Number of table entries for a ramp phase.
    function automatic logic [2:0] ramp_size(input phase_t ph);
        logic [2:0] size;
        if (ph == PH_DOWN) begin
            size = 3'd3;
        end else begin
            size = 3'd4;
        end
        return size;
    endfunction

    // Table voltage for a ramp phase and step.
    function automatic logic [MV_W-1:0] ramp_mv(input phase_t ph, input logic [2:0] step);
        logic [MV_W-1:0] mv;
        if (ph == PH_DOWN) begin
            unique case (step)
                3'd0:    mv = 14'd4000;
                3'd1:    mv = 14'd2000;
                default: mv = 14'd0;
            endcase
        end else begin
            unique case (step)
                3'd0:    mv = 14'd8000;
                3'd1:    mv = 14'd10000;
                3'd2:    mv = 14'd12000;
                3'd3:    mv = 14'd8000;
                default: mv = 14'd0;
            endcase
        end
        return mv;
    endfunction

endpackage

[hw/rtl/vrs_timeout.sv]
// Shared elapsed-time compare: (now - stamp) >= wait, modulo 2^32.
module vrs_timeout (
    input  logic [vrs_pkg::STAMP_W-1:0] now,
    input  logic [vrs_pkg::STAMP_W-1:0] stamp,
    input  logic [vrs_pkg::CFG_W-1:0]   wait_ms,
    output logic                        expired
);

    logic [vrs_pkg::STAMP_W-1:0] elapsed;

    assign elapsed = now - stamp;
    assign expired = elapsed >= {{(vrs_pkg::STAMP_W - vrs_pkg::CFG_W){1'b0}}, wait_ms};

endmodule

[hw/rtl/valve_ramp_sequencer.sv]
// Valve ramp sequencer top level: ramp stepping, three-valve cycle, result queue.
//
//  channel | ports                         | word
//  --------+-------------------------------+---------------------------------
//  input   | s_valid, s_ready, s_data      | tick or set command (in_t)
//  result  | m_valid, m_ready, m_data      | voltage write or acknowledge (out_t)
//  config  | cfg_wr_en, cfg_index, cfg_wr_data | register write, no wait
//
// A tick passes through the ramp, sequence and finish states, a set command through
// the set and acknowledge states; one elapsed-time comparator serves every valve
// in turn, one valve a cycle. Results (at most 5 a word) are queued and then sent
// one a cycle, while the receiver is ready, through the output register.
// The output register may hold a result while the next word is accepted.
// Reset is synchronous: all valves down done, counters and stamps zero.
module valve_ramp_sequencer #(
    parameter int NUM_VALVES = vrs_pkg::NUM_VALVES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vrs_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output vrs_pkg::out_t                 m_data,
    input  logic                          cfg_wr_en,
    input  logic [vrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vrs_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int VW = $clog2(NUM_VALVES);

    vrs_pkg::state_t state_reg, state_next;
    logic [vrs_pkg::STAMP_W-1:0] ms_reg, ms_next;
    vrs_pkg::phase_t phase_reg [NUM_VALVES];
    vrs_pkg::phase_t phase_next [NUM_VALVES];
    logic [2:0] step_reg [NUM_VALVES];
    logic [2:0] step_next [NUM_VALVES];
    logic [vrs_pkg::STAMP_W-1:0] stamp_reg [NUM_VALVES];
    logic [vrs_pkg::STAMP_W-1:0] stamp_next [NUM_VALVES];
    logic [vrs_pkg::STAMP_W-1:0] hold_stamp_reg, hold_stamp_next;
    logic hold_restart_reg, hold_restart_next;
    logic [1:0] active_reg, active_next;
    logic [VW-1:0] vidx_reg, vidx_next;
    vrs_pkg::in_t cmd_reg, cmd_next;
    logic [vrs_pkg::RES_CW-1:0] cnt_reg, cnt_next;
    logic [vrs_pkg::RES_CW-1:0] rd_reg, rd_next;
    vrs_pkg::out_t buf_reg [vrs_pkg::MAX_RESULTS];
    logic out_valid_reg, out_valid_next;
    vrs_pkg::out_t out_data_reg, out_data_next;

    logic [vrs_pkg::CFG_W-1:0] ramp_step_reg;
    logic [vrs_pkg::CFG_W-1:0] inflate_hold_reg;
    logic [vrs_pkg::CFG_W-1:0] deflate_hold_reg;
    logic seq_en_reg;

    logic [VW-1:0] cur_idx;
    vrs_pkg::phase_t cur_phase;
    logic [2:0] cur_step;
    logic idx_ok;
    logic [vrs_pkg::STAMP_W-1:0] stamp_sel;
    logic [vrs_pkg::CFG_W-1:0] wait_sel;
    logic expired;
    logic emit_en;
    vrs_pkg::out_t emit_data;

    assign idx_ok = {1'b0, cmd_reg.valve_index} < 4'(NUM_VALVES);

    always_comb begin
        unique case (state_reg)
            vrs_pkg::ST_SEQ: cur_idx = VW'(active_reg);
            vrs_pkg::ST_SET,
            vrs_pkg::ST_ACK: cur_idx = VW'(cmd_reg.valve_index);
            default:         cur_idx = vidx_reg;
        endcase
    end

    assign cur_phase = phase_reg[cur_idx];
    assign cur_step  = step_reg[cur_idx];

    always_comb begin
        if (state_reg == vrs_pkg::ST_SEQ) begin
            stamp_sel = hold_stamp_reg;
            wait_sel  = (cur_phase == vrs_pkg::PH_UP_DONE) ? inflate_hold_reg
                                                          : deflate_hold_reg;
        end else begin
            stamp_sel = stamp_reg[cur_idx];
            wait_sel  = ramp_step_reg;
        end
    end

    vrs_timeout u_timeout (
        .now     (ms_reg),
        .stamp   (stamp_sel),
        .wait_ms (wait_sel),
        .expired (expired)
    );

    always_comb begin
        state_next        = state_reg;
        ms_next           = ms_reg;
        phase_next        = phase_reg;
        step_next         = step_reg;
        stamp_next        = stamp_reg;
        hold_stamp_next   = hold_stamp_reg;
        hold_restart_next = hold_restart_reg;
        active_next       = active_reg;
        vidx_next         = vidx_reg;
        cmd_next          = cmd_reg;
        rd_next           = rd_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg;
        emit_en           = 1'b0;
        emit_data         = '0;
        s_ready           = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            vrs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next = s_data;
                    rd_next  = '0;
                    if (s_data.command == vrs_pkg::CMD_SET) begin
                        state_next = vrs_pkg::ST_SET;
                    end else begin
                        ms_next    = ms_reg + 1'b1;
                        vidx_next  = '0;
                        state_next = vrs_pkg::ST_RAMP;
                    end
                end
            end
            vrs_pkg::ST_RAMP: begin
                if ((cur_phase == vrs_pkg::PH_UP || cur_phase == vrs_pkg::PH_DOWN) &&
                    expired) begin
                    if ({1'b0, cur_step} + 4'd1 < {1'b0, vrs_pkg::ramp_size(cur_phase)}) begin
                        step_next[cur_idx]   = cur_step + 3'd1;
                        stamp_next[cur_idx]  = ms_reg;
                        emit_en              = 1'b1;
                        emit_data.kind       = vrs_pkg::KIND_VOLT;
                        emit_data.valve      = 3'(cur_idx);
                        emit_data.voltage_mv = vrs_pkg::ramp_mv(cur_phase, cur_step + 3'd1);
                    end else begin
                        step_next[cur_idx]  = vrs_pkg::ramp_size(cur_phase);
                        phase_next[cur_idx] = (cur_phase == vrs_pkg::PH_UP) ?
                                              vrs_pkg::PH_UP_DONE : vrs_pkg::PH_DOWN_DONE;
                    end
                end
                if (vidx_reg == VW'(NUM_VALVES - 1)) begin
                    state_next = vrs_pkg::ST_SEQ;
                end else begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            vrs_pkg::ST_SEQ: begin
                state_next = vrs_pkg::ST_FIN;
                if (seq_en_reg && expired) begin
                    if (cur_phase == vrs_pkg::PH_UP_DONE) begin
                        phase_next[cur_idx]  = vrs_pkg::PH_DOWN;
                        step_next[cur_idx]   = 3'd0;
                        stamp_next[cur_idx]  = ms_reg;
                        emit_en              = 1'b1;
                        emit_data.kind       = vrs_pkg::KIND_VOLT;
                        emit_data.valve      = 3'(cur_idx);
                        emit_data.voltage_mv = vrs_pkg::ramp_mv(vrs_pkg::PH_DOWN, 3'd0);
                        hold_restart_next    = 1'b1;
                        // pass to the next valve; it is examined this tick unless we wrap
                        if (active_reg == 2'd2) begin
                            active_next = 2'd0;
                        end else begin
                            active_next = active_reg + 2'd1;
                            state_next  = vrs_pkg::ST_SEQ;
                        end
                    end else if (cur_phase == vrs_pkg::PH_DOWN_DONE) begin
                        phase_next[cur_idx]  = vrs_pkg::PH_UP;
                        step_next[cur_idx]   = 3'd0;
                        stamp_next[cur_idx]  = ms_reg;
                        emit_en              = 1'b1;
                        emit_data.kind       = vrs_pkg::KIND_VOLT;
                        emit_data.valve      = 3'(cur_idx);
                        emit_data.voltage_mv = vrs_pkg::ramp_mv(vrs_pkg::PH_UP, 3'd0);
                        hold_restart_next    = 1'b1;
                    end
                end
            end
            vrs_pkg::ST_FIN: begin
                if (hold_restart_reg) begin
                    hold_stamp_next   = ms_reg;
                    hold_restart_next = 1'b0;
                end
                state_next = (cnt_reg == '0) ? vrs_pkg::ST_IDLE : vrs_pkg::ST_DRAIN;
            end
            vrs_pkg::ST_SET: begin
                if (idx_ok && cur_phase != vrs_pkg::phase_t'(cmd_reg.new_state)) begin
                    phase_next[cur_idx] = vrs_pkg::phase_t'(cmd_reg.new_state);
                    step_next[cur_idx]  = 3'd0;
                    stamp_next[cur_idx] = ms_reg;
                    if (cmd_reg.new_state == vrs_pkg::PH_UP ||
                        cmd_reg.new_state == vrs_pkg::PH_DOWN) begin
                        emit_en              = 1'b1;
                        emit_data.kind       = vrs_pkg::KIND_VOLT;
                        emit_data.valve      = cmd_reg.valve_index;
                        emit_data.voltage_mv = vrs_pkg::ramp_mv(
                            vrs_pkg::phase_t'(cmd_reg.new_state), 3'd0);
                    end
                end
                state_next = vrs_pkg::ST_ACK;
            end
            vrs_pkg::ST_ACK: begin
                emit_en         = 1'b1;
                emit_data.kind  = vrs_pkg::KIND_ACK;
                emit_data.valve = cmd_reg.valve_index;
                emit_data.ok    = idx_ok;
                state_next      = vrs_pkg::ST_DRAIN;
            end
            vrs_pkg::ST_DRAIN: begin
                if (rd_reg == cnt_reg) begin
                    state_next = vrs_pkg::ST_IDLE;
                end else if (!out_valid_reg || m_ready) begin
                    out_valid_next     = 1'b1;
                    out_data_next      = buf_reg[rd_reg];
                    out_data_next.last = (rd_reg == cnt_reg - 1'b1);
                    rd_next            = rd_reg + 1'b1;
                end
            end
            default: begin
                state_next = vrs_pkg::ST_IDLE;
            end
        endcase
    end

    // queue count: clear on a new word, drop writes beyond the queue depth
    always_comb begin
        cnt_next = cnt_reg;
        if (s_valid && s_ready) begin
            cnt_next = '0;
        end else if (emit_en && cnt_reg < vrs_pkg::RES_CW'(vrs_pkg::MAX_RESULTS)) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= vrs_pkg::ST_IDLE;
            ms_reg           <= '0;
            hold_stamp_reg   <= '0;
            hold_restart_reg <= 1'b1;
            active_reg       <= '0;
            vidx_reg         <= '0;
            cnt_reg          <= '0;
            rd_reg           <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_VALVES; i++) begin
                phase_reg[i] <= vrs_pkg::PH_DOWN_DONE;
                step_reg[i]  <= '0;
                stamp_reg[i] <= '0;
            end
        end else begin
            state_reg        <= state_next;
            ms_reg           <= ms_next;
            hold_stamp_reg   <= hold_stamp_next;
            hold_restart_reg <= hold_restart_next;
            active_reg       <= active_next;
            vidx_reg         <= vidx_next;
            cnt_reg          <= cnt_next;
            rd_reg           <= rd_next;
            out_valid_reg    <= out_valid_next;
            phase_reg        <= phase_next;
            step_reg         <= step_next;
            stamp_reg        <= stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        if (emit_en && cnt_reg < vrs_pkg::RES_CW'(vrs_pkg::MAX_RESULTS)) begin
            buf_reg[cnt_reg] <= emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg    <= vrs_pkg::RAMP_STEP_RST;
            inflate_hold_reg <= vrs_pkg::INFLATE_HOLD_RST;
            deflate_hold_reg <= vrs_pkg::DEFLATE_HOLD_RST;
            seq_en_reg       <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (vrs_pkg::reg_idx_t'(cfg_index))
                vrs_pkg::REG_RAMP_STEP:    ramp_step_reg    <= cfg_wr_data;
                vrs_pkg::REG_INFLATE_HOLD: inflate_hold_reg <= cfg_wr_data;
                vrs_pkg::REG_DEFLATE_HOLD: deflate_hold_reg <= cfg_wr_data;
                vrs_pkg::REG_SEQ_ENABLE:   seq_en_reg       <= cfg_wr_data[0];
                default:                   seq_en_reg       <= seq_en_reg;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
